/* rtl/multi_stack_shared_store_assert.svh */
// Assertion macros for the multi-stack shared store.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef MULTI_STACK_SHARED_STORE_ASSERT_SVH
`define MULTI_STACK_SHARED_STORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define MSS_ASSERT_IMPL(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("multi_stack_shared_store: property failed");

// Next-cycle implication, disabled while reset is held.
`define MSS_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("multi_stack_shared_store: property failed");

`endif

/* rtl/mss_pkg.sv */
// Shared types and codes for the multi-stack shared store.
// No dependencies; used by the controller, datapath and checker.
`default_nettype none

package mss_pkg;

  // Operation codes on the action field.
  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_TOP,
    S_POP
  } mss_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;       // latch the word, read top and free-head link
    logic commit_push;  // write data, link and top for a push
    logic pop_read;     // read link and data of the popped slot
    logic commit_pop;   // unlink top and return slot to the free list
    logic fail;         // report overflow or underflow, change nothing
  } mss_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_push;
    logic push_ok;
    logic pop_ok;
    logic out_free;
  } mss_stat_t;

endpackage

`default_nettype wire

/* rtl/mss_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                         wdata_i,
  input  wire logic                                     re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output      logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/mss_ctrl.sv */
// Controller state machine of the multi-stack shared store.
// Depends on mss_pkg for the state enum and the command and status structs.
`default_nettype none

module mss_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_stall_o,
  input  wire mss_pkg::mss_stat_t stat_i,
  output      mss_pkg::mss_cmd_t  cmd_o
);

  mss_pkg::mss_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mss_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands. Commits wait until the output register is free.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      mss_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = mss_pkg::S_TOP;
        end
      end
      mss_pkg::S_TOP: begin
        if (stat_i.out_free) begin
          priority if (stat_i.is_push) begin
            cmd_o.commit_push = stat_i.push_ok;
            cmd_o.fail        = !stat_i.push_ok;
            state_d           = mss_pkg::S_IDLE;
          end else if (stat_i.pop_ok) begin
            cmd_o.pop_read = 1'b1;
            state_d        = mss_pkg::S_POP;
          end else begin
            cmd_o.fail = 1'b1;
            state_d    = mss_pkg::S_IDLE;
          end
        end
      end
      mss_pkg::S_POP: begin
        if (stat_i.out_free) begin
          cmd_o.commit_pop = 1'b1;
          state_d          = mss_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = mss_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/mss_dp.sv */
// Datapath of the multi-stack shared store: stores, free list, output register.
// Depends on mss_pkg and mss_ram.
`default_nettype none

module mss_dp #(
  parameter int NUM_STACKS = 8,
  parameter int CAPACITY   = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               action_i,
  input  wire logic [2:0]         stack_id_i,
  input  wire logic signed [31:0] value_i,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      logic signed [31:0] popped_value_o,
  output      logic [1:0]         status_o,
  input  wire mss_pkg::mss_cmd_t  cmd_i,
  output      mss_pkg::mss_stat_t stat_o
);

  // Pointers carry one extra code: CAPACITY stands for a null link.
  localparam int PW   = $clog2(CAPACITY + 1);
  localparam int SLW  = $clog2(CAPACITY);
  localparam int SW   = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int SIDW = ((SW > 3) ? SW : 3) + 1;
  localparam logic [PW-1:0] NULL_PTR = PW'(CAPACITY);

  // Latched item and control registers.
  logic              act_q;
  logic [SIDW-1:0]   sid_q;
  logic [31:0]       val_q;
  logic [PW-1:0]     free_head_q, free_head_d;
  logic [PW-1:0]     hw_q, hw_d;
  logic [SLW-1:0]    rd_slot_q;
  logic [NUM_STACKS-1:0] top_vld_q;
  logic              out_valid_q;
  logic [31:0]       popped_q;
  logic [1:0]        status_q;

  logic [SIDW-1:0]   sid_in;
  logic [SW-1:0]     sid_addr;
  logic              sid_ok;
  logic [PW-1:0]     top_rdata, top_eff, top_wdata;
  logic [PW-1:0]     link_rdata, link_eff, link_wdata;
  logic [31:0]       data_rdata;
  logic              top_we, link_we, link_re;
  logic [SLW-1:0]    link_raddr, link_waddr, fh_slot, top_slot;
  logic              out_load;

  assign sid_in   = SIDW'(stack_id_i);
  assign sid_addr = sid_q[SW-1:0];
  assign sid_ok   = sid_q < SIDW'(NUM_STACKS);
  assign fh_slot  = free_head_q[SLW-1:0];

  // Item register, loaded on accept.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      act_q <= action_i;
      sid_q <= sid_in;
      val_q <= value_i;
    end
  end

  // Stack tops: an entry not yet written reads as null.
  assign top_eff  = top_vld_q[sid_addr] ? top_rdata : NULL_PTR;
  assign top_slot = top_eff[SLW-1:0];

  // Slots at or above the high-water mark still hold their reset link.
  assign link_eff = (PW'(rd_slot_q) >= hw_q) ? PW'(rd_slot_q) + PW'(1) : link_rdata;

  // Read addresses: free head on accept, top slot before a pop commit.
  assign link_re    = cmd_i.accept | cmd_i.pop_read;
  assign link_raddr = cmd_i.pop_read ? top_slot : fh_slot;

  always_ff @(posedge clk_i) begin
    if (link_re) begin
      rd_slot_q <= link_raddr;
    end
  end

  // Write selection for the link and top stores.
  assign link_we    = cmd_i.commit_push | cmd_i.commit_pop;
  assign link_waddr = cmd_i.commit_pop ? rd_slot_q : fh_slot;
  assign link_wdata = cmd_i.commit_pop ? free_head_q : top_eff;
  assign top_we     = cmd_i.commit_push | cmd_i.commit_pop;
  assign top_wdata  = cmd_i.commit_pop ? link_eff : free_head_q;

  mss_ram #(.WIDTH(PW), .DEPTH(NUM_STACKS)) u_top_ram (
    .clk_i   (clk_i),
    .we_i    (top_we),
    .waddr_i (sid_addr),
    .wdata_i (top_wdata),
    .re_i    (cmd_i.accept),
    .raddr_i (sid_in[SW-1:0]),
    .rdata_o (top_rdata)
  );

  mss_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .re_i    (link_re),
    .raddr_i (link_raddr),
    .rdata_o (link_rdata)
  );

  mss_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit_push),
    .waddr_i (fh_slot),
    .wdata_i (val_q),
    .re_i    (cmd_i.pop_read),
    .raddr_i (top_slot),
    .rdata_o (data_rdata)
  );

  // Free-list head and high-water mark.
  always_comb begin
    free_head_d = free_head_q;
    hw_d        = hw_q;
    if (cmd_i.commit_push) begin
      free_head_d = link_eff;
      if (free_head_q == hw_q) begin
        hw_d = hw_q + PW'(1);
      end
    end else if (cmd_i.commit_pop) begin
      free_head_d = PW'(rd_slot_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q <= '0;
      hw_q        <= '0;
      top_vld_q   <= '0;
    end else begin
      free_head_q <= free_head_d;
      hw_q        <= hw_d;
      if (top_we) begin
        top_vld_q[sid_addr] <= 1'b1;
      end
    end
  end

  // Output register.
  assign out_load = cmd_i.commit_push | cmd_i.commit_pop | cmd_i.fail;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      popped_q <= cmd_i.commit_pop ? data_rdata : '0;
      priority if (!cmd_i.fail) begin
        status_q <= mss_pkg::ST_DONE;
      end else if (act_q == mss_pkg::ACT_PUSH) begin
        status_q <= mss_pkg::ST_OVERFLOW;
      end else begin
        status_q <= mss_pkg::ST_UNDERFLOW;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign popped_value_o = $signed(popped_q);
  assign status_o       = status_q;

  // Status to the controller.
  assign stat_o.is_push  = act_q == mss_pkg::ACT_PUSH;
  assign stat_o.push_ok  = sid_ok && (free_head_q < NULL_PTR);
  assign stat_o.pop_ok   = sid_ok && (top_eff < NULL_PTR);
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

endmodule

`default_nettype wire

/* rtl/multi_stack_shared_store.sv */
// Order: a push is accepted in the idle state and commits from the top state;
// a pop passes through the top and pop states. This is set by the registered
// reads of the top, link and data memories. One item is taken at a time;
// commits wait while a finished result is still stalled in the output register.
// Reset: all stacks empty, free list starts at slot zero. No clearing pass;
// a high-water mark supplies the initial links of slots not yet used.
`default_nettype none

module multi_stack_shared_store #(
  parameter int NUM_STACKS = 8,
  parameter int CAPACITY   = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire logic               action_i,
  input  wire logic [2:0]         stack_id_i,
  input  wire logic signed [31:0] value_i,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      logic signed [31:0] popped_value_o,
  output      logic [1:0]         status_o
);

  mss_pkg::mss_cmd_t  cmd;
  mss_pkg::mss_stat_t stat;

  // Sequencer.
  mss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Stores, free list and result register.
  mss_dp #(.NUM_STACKS(NUM_STACKS), .CAPACITY(CAPACITY)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .action_i       (action_i),
    .stack_id_i     (stack_id_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .popped_value_o (popped_value_o),
    .status_o       (status_o),
    .cmd_i          (cmd),
    .stat_o         (stat)
  );

endmodule

`default_nettype wire

/* rtl/mss_checker.sv */
// Port-level checker for the multi-stack shared store, bound to the top level.
// Depends on mss_pkg and the assertion macros header.
`default_nettype none
`include "multi_stack_shared_store_assert.svh"

module mss_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic signed [31:0] popped_value_o,
  input wire logic [1:0]         status_o
);

  logic in_acc;
  logic out_blocked;
  logic status_legal;
  logic fail_word;

  assign in_acc       = in_valid_i && !in_stall_o;
  assign out_blocked  = out_valid_o && out_stall_i;
  assign status_legal = (status_o == mss_pkg::ST_DONE) ||
                        (status_o == mss_pkg::ST_OVERFLOW) ||
                        (status_o == mss_pkg::ST_UNDERFLOW);
  assign fail_word    = out_valid_o && (status_o != mss_pkg::ST_DONE);

  // A stalled word holds its value.
  `MSS_ASSERT_NEXT(a_out_hold, out_blocked, out_valid_o && $stable({popped_value_o, status_o}))

  // Only the three defined status codes appear.
  `MSS_ASSERT_IMPL(a_status_code, out_valid_o, status_legal)

  // Failed operations carry a zero value.
  `MSS_ASSERT_IMPL(a_fail_zero, fail_word, popped_value_o == 32'sd0)

  // One item at a time: the input stalls right after an accept.
  `MSS_ASSERT_NEXT(a_busy_after_accept, in_acc, in_stall_o)

endmodule

bind multi_stack_shared_store mss_checker u_mss_checker (.*);

`default_nettype wire
